### src/edfsched_pkg.sv
// ----------------------------------------------------------------------------
// EDF scheduler package
// Word types, field widths, defaults and codes shared by the scheduler files.
// ----------------------------------------------------------------------------
package edfsched_pkg;

   localparam int DEF_MAX_TASKS = 16;
   localparam int DEF_TIME_BITS = 32;

   localparam int ACT_BITS   = 5;
   localparam int SLOT_BITS  = 4;
   localparam int FIELD_BITS = 16;
   localparam int OUT_TIME_BITS = 32;

   localparam logic [ACT_BITS-1:0] ACTIVE_RESET = 5'd1;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   typedef struct packed {
      logic                  kind;
      logic [SLOT_BITS-1:0]  task_slot;
      logic [FIELD_BITS-1:0] exec_time;
      logic [FIELD_BITS-1:0] task_period;
      logic [FIELD_BITS-1:0] rel_deadline;
   } req_word_type;

   typedef struct packed {
      logic [OUT_TIME_BITS-1:0] tick_time;
      logic [SLOT_BITS-1:0]     run_task;
      logic                     idle;
   } rsp_word_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] exec_time;
      logic [FIELD_BITS-1:0] task_period;
      logic [FIELD_BITS-1:0] rel_deadline;
   } task_param_type;

endpackage

### src/edf_periodic_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// EDF periodic task scheduler
// Channel  Dir  Handshake          Word
// req      in   req_valid/stall    req_word: load a task entry or one tick
// rsp      out  rsp_valid/stall    rsp_word: tick time, task that ran, idle
// csr      in   csr_valid/ready    csr_active_tasks: number of active tasks
//
// A tick word makes one pass over the task memories, one read a cycle, for each
// active task (csr_active_tasks, at most MAX_TASKS), then waits until the output
// is free, writes back the chosen task and loads the result.
// Reset is synchronous; task job state reads as zero until first written.
// A waiting result holds up only the done state of the next tick.
// ----------------------------------------------------------------------------
module edf_periodic_task_scheduler_unit #(
   parameter int MAX_TASKS = edfsched_pkg::DEF_MAX_TASKS,
   parameter int TIME_BITS = edfsched_pkg::DEF_TIME_BITS
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  edfsched_pkg::req_word_type               req_word,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output edfsched_pkg::rsp_word_type               rsp_word,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [edfsched_pkg::ACT_BITS-1:0]        csr_active_tasks
);
   import edfsched_pkg::*;

   localparam int IDX_BITS = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_BITS = $clog2(MAX_TASKS + 1);
   localparam int CMP_BITS = (CNT_BITS > ACT_BITS) ? CNT_BITS : ACT_BITS;
   localparam int DYN_BITS = FIELD_BITS + 2 * TIME_BITS;
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                    input logic [FIELD_BITS-1:0] b);
      logic [TIME_BITS:0] sum;
      sum = {1'b0, a} + (TIME_BITS + 1)'(b);
      return sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
   endfunction

   task_param_type        param_mem [MAX_TASKS];
   logic [DYN_BITS-1:0]   dyn_mem [MAX_TASKS];
   task_param_type        param_rd_ff;
   logic [DYN_BITS-1:0]   dyn_rd_ff;

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   rd_cnt_ff, rd_cnt_in;
   logic                  s1_vld_ff, s1_vld_in;
   logic [IDX_BITS-1:0]   s1_idx_ff, s1_idx_in;
   logic                  s1_live_ff, s1_live_in;
   logic [TIME_BITS-1:0]  now_ff, now_in;
   logic [ACT_BITS-1:0]   active_ff, active_in;
   logic                  found_ff, found_in;
   logic [IDX_BITS-1:0]   pick_ff, pick_in;
   logic [TIME_BITS-1:0]  best_due_ff, best_due_in;
   logic [TIME_BITS-1:0]  best_rel_ff, best_rel_in;
   logic [FIELD_BITS-1:0] best_work_ff, best_work_in;
   logic [MAX_TASKS-1:0]  dyn_valid_ff, dyn_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   logic                  rd_en;
   logic [IDX_BITS-1:0]   rd_addr;
   logic                  prm_we;
   logic [IDX_BITS-1:0]   prm_waddr;
   logic                  dyn_we;
   logic [IDX_BITS-1:0]   dyn_waddr;
   logic [DYN_BITS-1:0]   dyn_wdata;

   logic                  req_take;
   logic                  slot_ok;
   logic [CMP_BITS-1:0]   act_ext;
   logic [CMP_BITS-1:0]   max_ext;
   logic [CMP_BITS-1:0]   count;
   logic                  scan_more;
   logic [DYN_BITS-1:0]   dyn_cur;
   logic [FIELD_BITS-1:0] cur_work;
   logic [TIME_BITS-1:0]  cur_rel;
   logic [TIME_BITS-1:0]  cur_due;
   logic                  released;
   logic [FIELD_BITS-1:0] new_work;
   logic [TIME_BITS-1:0]  new_rel;
   logic [TIME_BITS-1:0]  new_due;
   logic                  better;
   logic                  out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign slot_ok   = (int'(req_word.task_slot) < MAX_TASKS);
   assign act_ext   = CMP_BITS'(active_ff);
   assign max_ext   = CMP_BITS'(MAX_TASKS);
   assign count     = (act_ext > max_ext) ? max_ext : act_ext;
   assign scan_more = (CMP_BITS'(rd_cnt_ff) < count);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign dyn_cur  = s1_live_ff ? dyn_rd_ff : '0;
   assign cur_work = dyn_cur[DYN_BITS-1 -: FIELD_BITS];
   assign cur_rel  = dyn_cur[2*TIME_BITS-1 -: TIME_BITS];
   assign cur_due  = dyn_cur[TIME_BITS-1:0];
   assign released = (cur_rel == now_ff);
   assign new_work = released ? param_rd_ff.exec_time : cur_work;
   assign new_rel  = released ? sat_add(cur_rel, param_rd_ff.task_period) : cur_rel;
   assign new_due  = released ? sat_add(now_ff, param_rd_ff.rel_deadline) : cur_due;
   assign better   = (new_work != '0) && (!found_ff || (new_due < best_due_ff));

   assign rd_en   = (state_ff == ST_SCAN) && scan_more;
   assign rd_addr = rd_cnt_ff[IDX_BITS-1:0];

   assign prm_we    = req_take && (req_word.kind == KIND_LOAD) && slot_ok;
   assign prm_waddr = IDX_BITS'(req_word.task_slot);

   always_comb begin
      dyn_we    = 1'b0;
      dyn_waddr = s1_idx_ff;
      dyn_wdata = {new_work, new_rel, new_due};
      if (s1_vld_ff) begin
         dyn_we = 1'b1;
      end else if ((state_ff == ST_DONE) && out_free && found_ff) begin
         dyn_we    = 1'b1;
         dyn_waddr = pick_ff;
         dyn_wdata = {best_work_ff - FIELD_BITS'(1), best_rel_ff, best_due_ff};
      end
   end

   always_comb begin
      state_in     = state_ff;
      rd_cnt_in    = rd_cnt_ff;
      s1_vld_in    = 1'b0;
      s1_idx_in    = rd_addr;
      s1_live_in   = dyn_valid_ff[rd_addr];
      now_in       = now_ff;
      active_in    = active_ff;
      found_in     = found_ff;
      pick_in      = pick_ff;
      best_due_in  = best_due_ff;
      best_rel_in  = best_rel_ff;
      best_work_in = best_work_ff;
      dyn_valid_in = dyn_valid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;

      if (csr_valid) begin
         active_in = csr_active_tasks;
      end

      if (prm_we) begin
         dyn_valid_in[prm_waddr] = 1'b0;
         now_in = '0;
      end

      if (dyn_we) begin
         dyn_valid_in[dyn_waddr] = 1'b1;
      end

      if (s1_vld_ff && better) begin
         found_in     = 1'b1;
         pick_in      = s1_idx_ff;
         best_due_in  = new_due;
         best_rel_in  = new_rel;
         best_work_in = new_work;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_word.kind == KIND_TICK)) begin
               rd_cnt_in = '0;
               found_in  = 1'b0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_more) begin
               s1_vld_in = 1'b1;
               rd_cnt_in = rd_cnt_ff + CNT_BITS'(1);
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_word_in.tick_time = OUT_TIME_BITS'(now_ff);
               rsp_word_in.run_task  = found_ff ? SLOT_BITS'(pick_ff) : '0;
               rsp_word_in.idle      = !found_ff;
               now_in                = sat_add(now_ff, FIELD_BITS'(1));
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (prm_we) begin
         param_mem[prm_waddr] <= '{req_word.exec_time, req_word.task_period,
                                   req_word.rel_deadline};
      end
      if (rd_en) begin
         param_rd_ff <= param_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (dyn_we) begin
         dyn_mem[dyn_waddr] <= dyn_wdata;
      end
      if (rd_en) begin
         dyn_rd_ff <= dyn_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         s1_vld_ff    <= 1'b0;
         now_ff       <= '0;
         active_ff    <= ACTIVE_RESET;
         found_ff     <= 1'b0;
         dyn_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_vld_ff    <= s1_vld_in;
         now_ff       <= now_in;
         active_ff    <= active_in;
         found_ff     <= found_in;
         dyn_valid_ff <= dyn_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_cnt_ff    <= rd_cnt_in;
      s1_idx_ff    <= s1_idx_in;
      s1_live_ff   <= s1_live_in;
      pick_ff      <= pick_in;
      best_due_ff  <= best_due_in;
      best_rel_ff  <= best_rel_in;
      best_work_ff <= best_work_in;
      rsp_word_ff  <= rsp_word_in;
   end

endmodule
